// File: rtl/u8dc_pkg.sv
// ----------------------------------------------------------------------------
// u8dc_pkg
// Shared types and constants for the UTF-8 decoder / classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dc_pkg;

  localparam int unsigned CODE_W  = 31;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CLASS_W = 4;

  typedef enum logic [CLASS_W-1:0] {
    SC_LATIN    = 4'd0,
    SC_GREEK    = 4'd1,
    SC_CYRILLIC = 4'd2,
    SC_ARMENIAN = 4'd3,
    SC_HEBREW   = 4'd4,
    SC_ARABIC   = 4'd5,
    SC_CJK      = 4'd6,
    SC_PUNCT    = 4'd7,
    SC_DIGIT    = 4'd8,
    SC_EMOJI    = 4'd9,
    SC_UNKNOWN  = 4'd10
  } script_t;

  // classifier result handed back to the top level
  typedef struct packed {
    script_t script;
    logic    full_width;
  } class_res_t;

endpackage

`default_nettype wire

// File: rtl/u8dc_if.sv
// ----------------------------------------------------------------------------
// u8dc_if
// Valid/ready channel interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dc_in_if;
  logic                          valid;
  logic                          ready;
  logic [u8dc_pkg::BYTE_W-1:0]   byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8dc_out_if;
  logic                          valid;
  logic                          ready;
  logic [u8dc_pkg::CODE_W-1:0]   code_point;
  logic [u8dc_pkg::CLASS_W-1:0]  script_class;
  logic                          full_width;
  logic [u8dc_pkg::LEN_W-1:0]    byte_length;

  modport source (output valid, output code_point, output script_class,
                  output full_width, output byte_length, input ready);
  modport sink   (input valid, input code_point, input script_class,
                  input full_width, input byte_length, output ready);
endinterface

`default_nettype wire

// File: rtl/u8dc_classify.sv
// ----------------------------------------------------------------------------
// u8dc_classify
// Script class and full-width flag of a code point (pure range compares).
// ----------------------------------------------------------------------------
`default_nettype none

module u8dc_classify (
  input  logic [u8dc_pkg::CODE_W-1:0] code,
  output u8dc_pkg::class_res_t        res
);

  function automatic logic in_rng(input logic [u8dc_pkg::CODE_W-1:0] v,
                                  input logic [u8dc_pkg::CODE_W-1:0] lo,
                                  input logic [u8dc_pkg::CODE_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  logic cjk, emoji, latin, punct, fw;

  always_comb begin
    cjk   = in_rng(code, 31'h1100, 31'h115F)  || in_rng(code, 31'h2E80, 31'h303E) ||
            in_rng(code, 31'h3041, 31'h33FF)  || in_rng(code, 31'h3400, 31'h4DBF) ||
            in_rng(code, 31'h4E00, 31'h9FFF)  || in_rng(code, 31'hF900, 31'hFAFF) ||
            in_rng(code, 31'hFE30, 31'hFE6F)  || in_rng(code, 31'h20000, 31'h3FFFD);
    emoji = in_rng(code, 31'h1F300, 31'h1F64F) || in_rng(code, 31'h1F900, 31'h1F9FF);
    latin = in_rng(code, 31'h41, 31'h5A) || in_rng(code, 31'h61, 31'h7A) ||
            in_rng(code, 31'h80, 31'h24F);
    punct = in_rng(code, 31'h20, 31'h2F)     || in_rng(code, 31'h3A, 31'h40) ||
            in_rng(code, 31'h5B, 31'h60)     || in_rng(code, 31'h7B, 31'h7E) ||
            in_rng(code, 31'h2000, 31'h206F) || in_rng(code, 31'h3000, 31'h303F);
    fw    = cjk || emoji ||
            in_rng(code, 31'hA000, 31'hA4CF) || in_rng(code, 31'hAC00, 31'hD7A3) ||
            in_rng(code, 31'hFF00, 31'hFF60) || in_rng(code, 31'hFFE0, 31'hFFE6);

    res.full_width = fw;
    // first match wins
    if (latin)                                  res.script = u8dc_pkg::SC_LATIN;
    else if (in_rng(code, 31'h370, 31'h3FF))    res.script = u8dc_pkg::SC_GREEK;
    else if (in_rng(code, 31'h400, 31'h52F))    res.script = u8dc_pkg::SC_CYRILLIC;
    else if (in_rng(code, 31'h530, 31'h58F))    res.script = u8dc_pkg::SC_ARMENIAN;
    else if (in_rng(code, 31'h590, 31'h5FF))    res.script = u8dc_pkg::SC_HEBREW;
    else if (in_rng(code, 31'h600, 31'h6FF))    res.script = u8dc_pkg::SC_ARABIC;
    else if (cjk)                               res.script = u8dc_pkg::SC_CJK;
    else if (punct)                             res.script = u8dc_pkg::SC_PUNCT;
    else if (in_rng(code, 31'h30, 31'h39))      res.script = u8dc_pkg::SC_DIGIT;
    else if (emoji)                             res.script = u8dc_pkg::SC_EMOJI;
    else                                        res.script = u8dc_pkg::SC_UNKNOWN;
  end

endmodule

`default_nettype wire

// File: rtl/utf8_decode_classify.sv
// ----------------------------------------------------------------------------
// utf8_decode_classify
// UTF-8 byte stream decoder with script classification.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one raw byte per word (valid/ready).
//   out_ch : one word per completed character: code point, script class,
//            full-width flag and byte length (1 to 6).
//   A byte with no character open is a lead byte; 1-byte characters (and
//   stray continuation bytes) complete at once. Bytes after a lead are
//   taken as continuations unchecked, low six bits shifted in.
// Throughput: one byte per clock, sustained while out_ch is not stalled (see Stall).
// Path: a finished character's word reaches out_ch through the decode
//   register, then is classified into the output register.
// Reset: rst_n low clears the decode state and both pipeline stages; the
//   next byte after reset is read as a lead byte.
// Stall: when out_ch.ready is low the output word holds; the decode stage
//   keeps taking bytes until a second finished character waits behind it,
//   then in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_classify (
  input  logic              clk,
  input  logic              rst_n,
  u8dc_in_if.sink           in_ch,
  u8dc_out_if.source        out_ch
);

  localparam int unsigned CW = u8dc_pkg::CODE_W;
  localparam int unsigned LW = u8dc_pkg::LEN_W;

  // decode state
  logic [CW-1:0] partial_r, partial_nxt;
  logic [LW-1:0] remain_r, remain_nxt;
  logic [LW-1:0] clen_r, clen_nxt;

  // decode result stage
  logic          s1_valid_r;
  logic [CW-1:0] s1_code_r;
  logic [LW-1:0] s1_len_r;

  // output stage
  logic          out_valid_r;
  logic [CW-1:0] out_code_r;
  logic [u8dc_pkg::CLASS_W-1:0] out_class_r;
  logic          out_fw_r;
  logic [LW-1:0] out_len_r;

  logic          in_acc, out_free, s1_move, done;
  logic [CW-1:0] done_code;
  logic [LW-1:0] done_len;
  logic [7:0]    b;
  u8dc_pkg::class_res_t cls;

  assign b        = in_ch.byte_in;
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_comb begin
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    clen_nxt    = clen_r;
    done        = 1'b0;
    done_code   = {{(CW-8){1'b0}}, b};
    done_len    = 3'd1;
    if (remain_r != '0) begin
      partial_nxt = {partial_r[CW-7:0], b[5:0]};
      remain_nxt  = remain_r - 3'd1;
      done        = (remain_r == 3'd1);
      done_code   = partial_nxt;
      done_len    = clen_r;
    end else begin
      unique case (b) inside
        8'b0???????, 8'b10??????: begin
          done = 1'b1;
        end
        8'b110?????: begin
          partial_nxt = {{(CW-5){1'b0}}, b[4:0]};
          remain_nxt  = 3'd1;
          clen_nxt    = 3'd2;
        end
        8'b1110????: begin
          partial_nxt = {{(CW-4){1'b0}}, b[3:0]};
          remain_nxt  = 3'd2;
          clen_nxt    = 3'd3;
        end
        8'b11110???: begin
          partial_nxt = {{(CW-3){1'b0}}, b[2:0]};
          remain_nxt  = 3'd3;
          clen_nxt    = 3'd4;
        end
        8'b111110??: begin
          partial_nxt = {{(CW-2){1'b0}}, b[1:0]};
          remain_nxt  = 3'd4;
          clen_nxt    = 3'd5;
        end
        default: begin
          // 0xFC-0xFF: six-byte form
          partial_nxt = {{(CW-1){1'b0}}, b[0]};
          remain_nxt  = 3'd5;
          clen_nxt    = 3'd6;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= '0;
      clen_r    <= '0;
    end else if (in_acc) begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
      clen_r    <= clen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && done) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && done) begin
      s1_code_r <= done_code;
      s1_len_r  <= done_len;
    end
  end

  u8dc_classify u_classify (
    .code (s1_code_r),
    .res  (cls)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_code_r  <= s1_code_r;
      out_class_r <= cls.script;
      out_fw_r    <= cls.full_width;
      out_len_r   <= s1_len_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = out_code_r;
  assign out_ch.script_class = out_class_r;
  assign out_ch.full_width   = out_fw_r;
  assign out_ch.byte_length  = out_len_r;

  // at most five continuations are ever outstanding
  a_remain_max: assert property (@(posedge clk) disable iff (!rst_n)
    remain_r <= 3'd5)
    else $error("continuation count out of range");

  // an open character always has a length above its remaining count
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (remain_r != 3'd0) |-> (clen_r >= 3'd2 && clen_r <= 3'd6 && remain_r < clen_r))
    else $error("open character length inconsistent");

  // last continuation accepted -> decoded word waits in stage 1
  a_last_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && remain_r == 3'd1) |=> s1_valid_r)
    else $error("completed character lost");

  // stage 1 holds a word whenever it could not move on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_code_r)))
    else $error("stage 1 word dropped under stall");

endmodule

`default_nettype wire
